// ----- hw/rtl/assert_macros.svh -----
// assertion macros used by the rtl top level of the echo comb block
// no dependencies; included by files that carry concurrent assertions
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising edge outside reset
`define FEC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising edge outside reset
`define FEC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/fec_pkg.sv -----
// shared types and constants of the feedback echo comb block
// no dependencies; imported by every module of the block but fec_ram
`timescale 1ns / 1ps
`default_nettype none

package fec_pkg;

    // sample format: 16-bit two's complement
    localparam int SAMPLE_W = 16;
    typedef logic signed [SAMPLE_W-1:0] t_sample;

    localparam t_sample SAMPLE_MAX = 16'sh7FFF;
    localparam t_sample SAMPLE_MIN = 16'sh8000;

    // configuration port
    localparam int CFG_W   = 16;
    localparam int DELAY_W = 15;

    typedef enum logic {
        REG_DELAY = 1'b0,
        REG_DECAY = 1'b1
    } t_cfg_idx;

    // product of sample and Q1.15 gain, rounding back to Q.15
    localparam int PROD_W  = 2 * SAMPLE_W;
    localparam int Q_FRAC  = 15;
    localparam int SCALE_W = SAMPLE_W + 1;
    localparam int SUM_W   = SAMPLE_W + 2;
    localparam logic signed [PROD_W-1:0] ROUND_BIAS = 32'sd16384;

    // one result item
    typedef struct packed {
        t_sample sample;
        logic    clipped;
    } t_result;

    // output queue
    localparam int OQ_DEPTH = 4;
    localparam int OQ_AW    = 2;
    localparam int OQ_CW    = 3;

endpackage

`default_nettype wire

// ----- hw/rtl/fec_ram.sv -----
// generic single-port-write, single-port-read ram with registered read data
// read-first on a same-address collision; no dependencies
`timescale 1ns / 1ps
`default_nettype none

module fec_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 16384
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [W-1:0]             i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    // registered read, write at the same edge
    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ----- hw/rtl/fec_mac.sv -----
// multiply stage and round/add/saturate stage of the echo comb
// depends on fec_pkg
`timescale 1ns / 1ps
`default_nettype none

module fec_mac #(
    parameter int AW = 14
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire logic              i_use_echo,
    input  wire fec_pkg::t_sample  i_x,
    input  wire fec_pkg::t_sample  i_echo,
    input  wire fec_pkg::t_sample  i_gain,
    input  wire logic [AW-1:0]     i_ptr,
    output logic                   o_valid,
    output logic [AW-1:0]          o_ptr,
    output fec_pkg::t_result       o_res
);

    import fec_pkg::*;

    logic                     r_v2;
    logic                     r_use2;
    t_sample                  r_x2;
    logic [AW-1:0]            r_ptr2;
    logic signed [PROD_W-1:0] r_prod;

    logic signed [PROD_W-1:0]  n_prod;
    logic signed [PROD_W-1:0]  biased;
    logic signed [SCALE_W-1:0] scaled;
    logic signed [SUM_W-1:0]   sum;
    t_result                   res;

    // exact product of delayed output and gain
    assign n_prod = PROD_W'(i_echo) * PROD_W'(i_gain);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else begin
            r_v2 <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_use2 <= i_use_echo;
        r_x2   <= i_x;
        r_ptr2 <= i_ptr;
        r_prod <= n_prod;
    end

    // round to nearest with ties up, add input, saturate
    assign biased = r_prod + ROUND_BIAS;
    assign scaled = SCALE_W'(biased >>> Q_FRAC);
    assign sum    = SUM_W'(r_x2) + SUM_W'(scaled);

    always_comb begin
        res.sample  = r_x2;
        res.clipped = 1'b0;
        if (r_use2) begin
            priority if (sum > SUM_W'(SAMPLE_MAX)) begin
                res.sample  = SAMPLE_MAX;
                res.clipped = 1'b1;
            end else if (sum < SUM_W'(SAMPLE_MIN)) begin
                res.sample  = SAMPLE_MIN;
                res.clipped = 1'b1;
            end else begin
                res.sample  = SAMPLE_W'(sum);
            end
        end
    end

    assign o_valid = r_v2;
    assign o_ptr   = r_ptr2;
    assign o_res   = res;

endmodule

`default_nettype wire

// ----- hw/rtl/fec_oq.sv -----
// four-entry output queue that decouples the pipeline from the receiver
// depends on fec_pkg
`timescale 1ns / 1ps
`default_nettype none

module fec_oq (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_push,
    input  wire fec_pkg::t_result        i_data,
    input  wire logic                    i_ready,
    output logic                         o_valid,
    output fec_pkg::t_result             o_data,
    output logic [fec_pkg::OQ_CW-1:0]    o_count
);

    import fec_pkg::*;

    t_result           r_data [OQ_DEPTH];
    logic [OQ_AW-1:0]  r_wp;
    logic [OQ_AW-1:0]  r_rp;
    logic [OQ_CW-1:0]  r_count;
    logic              pop;

    assign pop = o_valid && i_ready;

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + OQ_AW'(1);
            end
            if (pop) begin
                r_rp <= r_rp + OQ_AW'(1);
            end
            r_count <= r_count + OQ_CW'(i_push) - OQ_CW'(pop);
        end
    end

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wp] <= i_data;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_data  = r_data[r_rp];
    assign o_count = r_count;

endmodule

`default_nettype wire

// ----- hw/rtl/feedback_echo_comb.sv -----
// feedback echo comb: top level with ring control, forwarding and config
// depends on fec_pkg, fec_ram, fec_mac, fec_oq and assert_macros.svh
//
// usage:
//   input channel: i_in_valid / o_in_ready carry one signed 16-bit sample
//   per item. output channel: o_out_valid / i_out_ready carry the echoed
//   sample and a saturation flag. config: i_cfg_we writes i_cfg_data into
//   register i_cfg_idx (0: delay in samples, 1: Q1.15 decay) at once;
//   write only while no item is in flight. a delay write restarts the ring.
// path: an accepted item passes the read stage, the multiply stage and the
//   output queue before its result is offered.
// throughput: one item per cycle for delays of two or more samples, while
//   the queue has room. with a delay of one sample each item needs the
//   output of the item just before it, not yet ready for a back-to-back
//   read, so o_in_ready stays low while an item is in the read stage.
// the ring lives in one ram of MAX_DELAY samples (one read and one write per
//   cycle); the last written sample is held in a bypass register.
// reset: delay 1, decay 0, ring restarted; ram contents are not cleared and
//   are used only after being written. no clearing pass is needed.
// stall: results collect in a four-entry queue; o_in_ready drops once the
//   queue and the two pipeline stages together hold four items.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module feedback_echo_comb #(
    parameter int MAX_DELAY = 16384
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    // input items
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire fec_pkg::t_sample  i_sample_in,
    // result items
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output fec_pkg::t_sample       o_sample_out,
    output logic                   o_clipped,
    // configuration writes
    input  wire logic                      i_cfg_we,
    input  wire fec_pkg::t_cfg_idx         i_cfg_idx,
    input  wire logic [fec_pkg::CFG_W-1:0] i_cfg_data
);

    import fec_pkg::*;

    localparam int AW = $clog2(MAX_DELAY);
    localparam int DW = $clog2(MAX_DELAY + 1);
    localparam int CW = (DW > DELAY_W) ? DW : DELAY_W;

    // config and ring control state
    logic [DW-1:0] r_delay;
    t_sample       r_gain;
    logic [AW-1:0] r_ptr;
    logic [DW-1:0] r_seen;

    // read stage
    logic          r_v1;
    logic          r_use1;
    t_sample       r_x1;
    logic [AW-1:0] r_ptr1;

    // bypass of the last ram write
    logic          r_fwd_v;
    logic [AW-1:0] r_fwd_addr;
    t_sample       r_fwd_data;

    logic             in_acc;
    logic             hazard;
    logic [OQ_CW-1:0] occ;
    logic [AW-1:0]    ptr_cur;
    logic [DW-1:0]    ptr_inc;
    logic [AW-1:0]    n_ptr;
    logic [DW-1:0]    n_seen;
    logic             use_echo;
    logic [CW-1:0]    cfg_delay;
    logic [DW-1:0]    n_delay;
    logic [SAMPLE_W-1:0] ram_rdata;
    t_sample          echo;
    logic             mac_v;
    logic [AW-1:0]    mac_ptr;
    t_result          mac_res;
    t_result          oq_data;
    logic [OQ_CW-1:0] oq_count;

    // admission: room for the item in the queue, no back-to-back with delay one
    assign occ        = oq_count + OQ_CW'(r_v1) + OQ_CW'(mac_v);
    assign hazard     = r_v1 && (r_delay == DW'(1));
    assign o_in_ready = (occ < OQ_CW'(OQ_DEPTH)) && !hazard;
    assign in_acc     = i_in_valid && o_in_ready;

    // ring pointer and fill count
    assign ptr_cur  = (DW'(r_ptr) >= r_delay) ? '0 : r_ptr;
    assign ptr_inc  = DW'(ptr_cur) + DW'(1);
    assign n_ptr    = (ptr_inc >= r_delay) ? '0 : AW'(ptr_inc);
    assign use_echo = (r_seen >= r_delay);
    assign n_seen   = use_echo ? r_seen : r_seen + DW'(1);

    // delay register clamp: zero means one, above the ring size means the ring size
    assign cfg_delay = CW'(i_cfg_data[DELAY_W-1:0]);
    always_comb begin
        priority if (cfg_delay == '0) begin
            n_delay = DW'(1);
        end else if (cfg_delay > CW'(MAX_DELAY)) begin
            n_delay = DW'(MAX_DELAY);
        end else begin
            n_delay = DW'(cfg_delay);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay <= DW'(1);
            r_gain  <= '0;
            r_ptr   <= '0;
            r_seen  <= '0;
            r_v1    <= 1'b0;
            r_fwd_v <= 1'b0;
        end else begin
            r_v1 <= in_acc;
            if (mac_v) begin
                r_fwd_v <= 1'b1;
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_DELAY: begin
                        r_delay <= n_delay;
                        r_ptr   <= '0;
                        r_seen  <= '0;
                    end
                    REG_DECAY: begin
                        r_gain <= t_sample'(i_cfg_data);
                    end
                    default: begin
                        r_gain <= r_gain;
                    end
                endcase
            end else if (in_acc) begin
                r_ptr  <= n_ptr;
                r_seen <= n_seen;
            end
        end
    end

    // read stage and bypass payload
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_use1 <= use_echo;
            r_x1   <= i_sample_in;
            r_ptr1 <= ptr_cur;
        end
        if (mac_v) begin
            r_fwd_addr <= mac_ptr;
            r_fwd_data <= mac_res.sample;
        end
    end

    // ring of past outputs; read at the current pointer every cycle
    fec_ram #(
        .W     (SAMPLE_W),
        .DEPTH (MAX_DELAY)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (mac_v),
        .i_waddr (mac_ptr),
        .i_wdata (mac_res.sample),
        .i_raddr (ptr_cur),
        .o_rdata (ram_rdata)
    );

    // a write at the edge of the read is not yet in the ram data
    assign echo = (r_fwd_v && (r_fwd_addr == r_ptr1)) ? r_fwd_data : t_sample'(ram_rdata);

    fec_mac #(
        .AW (AW)
    ) u_mac (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (r_v1),
        .i_use_echo (r_use1),
        .i_x        (r_x1),
        .i_echo     (echo),
        .i_gain     (r_gain),
        .i_ptr      (r_ptr1),
        .o_valid    (mac_v),
        .o_ptr      (mac_ptr),
        .o_res      (mac_res)
    );

    fec_oq u_oq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mac_v),
        .i_data  (mac_res),
        .i_ready (i_out_ready),
        .o_valid (o_out_valid),
        .o_data  (oq_data),
        .o_count (oq_count)
    );

    assign o_sample_out = oq_data.sample;
    assign o_clipped    = oq_data.clipped;

    // checks
    `FEC_ASSERT_NOW(a_no_overfill, i_clk, i_rst_n, 1'b1, occ <= OQ_CW'(OQ_DEPTH), "queue and pipeline hold more than the queue depth")
    `FEC_ASSERT_NOW(a_push_room, i_clk, i_rst_n, mac_v, oq_count < OQ_CW'(OQ_DEPTH), "result pushed into a full queue")
    `FEC_ASSERT_NOW(a_ptr_range, i_clk, i_rst_n, 1'b1, DW'(r_ptr) < r_delay, "ring pointer at or beyond the delay")
    `FEC_ASSERT_NEXT(a_delay_one_gap, i_clk, i_rst_n, in_acc && (r_delay == DW'(1)), !in_acc, "back-to-back items with a one-sample delay")

endmodule

`default_nettype wire

// ----- verif/tb_feedback_echo_comb.sv -----
// self-checking testbench for the feedback echo comb block
// depends on fec_pkg and feedback_echo_comb; predicts each echoed sample in a
// behavioral ring model and compares it with the dut output item by item
`timescale 1ns / 1ps

module tb_feedback_echo_comb;
    import fec_pkg::*;

    localparam int MAX_DELAY  = 16384;
    localparam int RAND_ITEMS = 1400;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_sample             i_sample_in;
    logic                o_out_valid;
    logic                i_out_ready;
    t_sample             o_sample_out;
    logic                o_clipped;
    logic                i_cfg_we;
    t_cfg_idx            i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;

    feedback_echo_comb #(
        .MAX_DELAY (MAX_DELAY)
    ) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_sample_in  (i_sample_in),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_sample_out (o_sample_out),
        .o_clipped    (o_clipped),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data)
    );

    // echo model state and its copy of the registers
    t_sample          echo_hist [MAX_DELAY];
    int               ring_pos;
    int               fill_count;
    logic [DELAY_W-1:0] delay_cfg;
    t_sample          gain_cfg;

    t_sample  sample_q[$];     // items waiting to be offered
    t_result  echo_exp_q[$];   // predicted results, oldest first
    bit       in_taken;
    bit       idle_en;
    int       stall_left;
    int       fail_cnt;

    // delay as the ring sees it: zero acts as one, large values clamp
    function automatic int eff_delay();
        int d;
        d = delay_cfg;
        if (d == 0) d = 1;
        if (d > MAX_DELAY) d = MAX_DELAY;
        return d;
    endfunction

    // one step of the comb: y = sat16(x + round(gain * y[n-D] / 2^15)), y = x while the ring fills
    function automatic t_result echo_predict(t_sample x);
        int      d;
        int      pos;
        longint  prod;
        longint  acc;
        t_result r;
        d   = eff_delay();
        pos = (ring_pos >= d) ? 0 : ring_pos;
        r.sample  = x;
        r.clipped = 1'b0;
        if (fill_count >= d) begin
            prod = longint'(echo_hist[pos]) * longint'(gain_cfg);
            acc  = longint'(x) + ((prod + 16384) >>> Q_FRAC);
            if (acc > 32767) begin
                r.sample  = SAMPLE_MAX;
                r.clipped = 1'b1;
            end else if (acc < -32768) begin
                r.sample  = SAMPLE_MIN;
                r.clipped = 1'b1;
            end else begin
                r.sample = t_sample'(acc);
            end
        end
        echo_hist[pos] = r.sample;
        pos++;
        ring_pos = (pos >= d) ? 0 : pos;
        if (fill_count < d) fill_count++;
        return r;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // input driver: offers queued items, with random gaps while idle_en is set
    always @(negedge i_clk) begin : drive_in
        logic    nxt_valid;
        t_sample nxt_data;
        nxt_valid = i_in_valid;
        nxt_data  = i_sample_in;
        if (in_taken) begin
            nxt_valid = 1'b0;
            in_taken  = 1'b0;
        end
        if (!nxt_valid && i_rst_n && sample_q.size() > 0
                && !(idle_en && $urandom_range(0, 99) < 10)) begin
            nxt_valid = 1'b1;
            nxt_data  = sample_q.pop_front();
        end
        i_in_valid  <= nxt_valid;
        i_sample_in <= nxt_data;
    end

    // output back-pressure: short bursts of stall, about one cycle in ten
    always @(negedge i_clk) begin : drive_out
        if (stall_left > 0)
            stall_left--;
        else if (idle_en && $urandom_range(0, 99) < 2)
            stall_left = $urandom_range(1, 8);
        i_out_ready <= (stall_left == 0);
    end

    // check results, then predict for the item accepted at this edge
    always @(posedge i_clk) begin : check_out
        t_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (echo_exp_q.size() == 0) begin
                $error("unexpected item: sample_out %0d clipped %0b",
                       o_sample_out, o_clipped);
                fail_cnt++;
            end else begin
                want = echo_exp_q.pop_front();
                if (o_sample_out !== want.sample) begin
                    $error("sample_out mismatch: expected %0d actual %0d",
                           want.sample, o_sample_out);
                    fail_cnt++;
                end
                if (o_clipped !== want.clipped) begin
                    $error("clipped mismatch: expected %0b actual %0b",
                           want.clipped, o_clipped);
                    fail_cnt++;
                end
            end
        end
        if (i_rst_n && i_in_valid && o_in_ready) begin
            echo_exp_q = {echo_exp_q, echo_predict(i_sample_in)};
            in_taken = 1'b1;
        end
    end

    // wait until nothing is queued, offered or outstanding
    task automatic wait_idle();
        while (sample_q.size() != 0 || i_in_valid || echo_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        if (idx == REG_DELAY) begin
            delay_cfg  = data[DELAY_W-1:0];
            ring_pos   = 0;
            fill_count = 0;
        end else begin
            gain_cfg = t_sample'(data);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // queue n random samples; amp 0 means full range
    task automatic push_random(int n, int amp);
        for (int k = 0; k < n; k++) begin
            if (amp == 0)
                sample_q = {sample_q, t_sample'($urandom)};
            else
                sample_q = {sample_q, t_sample'(int'($urandom_range(0, 2 * amp)) - amp)};
        end
    endtask

    function automatic logic [CFG_W-1:0] pick_gain();
        case ($urandom_range(0, 9))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'h0000;
            3: return 16'h4000;
            default: return CFG_W'($urandom);
        endcase
    endfunction

    // stimulus
    initial begin : stimulus
        int rand_cnt;
        int sel;
        int n;
        int amp;
        int d;
        fail_cnt   = 0;
        rand_cnt   = 0;
        in_taken   = 1'b0;
        idle_en    = 1'b1;
        stall_left = 0;
        ring_pos   = 0;
        fill_count = 0;
        delay_cfg  = 1;
        gain_cfg   = '0;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_sample_in = '0;
        i_out_ready = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = REG_DELAY;
        i_cfg_data  = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: one-sample delay, zero gain
        sample_q = '{SAMPLE_MAX, SAMPLE_MIN, 16'sd0, -16'sd1, 16'sd1};
        wait_idle();

        // half gain: rounding ties go toward plus infinity
        write_reg(REG_DECAY, 16'h4000);
        write_reg(REG_DELAY, 16'd1);
        sample_q = '{16'sd1, 16'sd0, 16'sd0, -16'sd1, 16'sd0, -16'sd3, 16'sd0};
        wait_idle();

        // zero delay acts as one; gain of minus one saturates both ways
        write_reg(REG_DECAY, 16'h8000);
        write_reg(REG_DELAY, 16'd0);
        sample_q = '{SAMPLE_MAX, SAMPLE_MIN, SAMPLE_MAX};
        wait_idle();

        // near unity gain, delay two, positive clipping
        write_reg(REG_DECAY, 16'h7FFF);
        write_reg(REG_DELAY, 16'd2);
        sample_q = '{SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX, SAMPLE_MAX,
                     SAMPLE_MIN, SAMPLE_MIN};
        wait_idle();

        // longest ring still filling, top data bit ignored, no idling on either side
        idle_en = 1'b0;
        write_reg(REG_DECAY, 16'h6000);
        write_reg(REG_DELAY, 16'hFFFF);
        push_random(300, 4096);
        wait_idle();
        idle_en = 1'b1;

        // delay above the maximum clamps to it
        write_reg(REG_DELAY, 16'h4001);
        push_random(60, 0);
        wait_idle();

        // random phases with changing settings
        while (rand_cnt < RAND_ITEMS) begin
            sel = $urandom_range(0, 99);
            if (sel < 70) begin
                case ($urandom_range(0, 2))
                    0: d = $urandom_range(0, 8);
                    1: d = $urandom_range(9, 64);
                    default: d = $urandom_range(65, 400);
                endcase
                write_reg(REG_DELAY, {1'($urandom_range(0, 1)), DELAY_W'(d)});
            end
            if (sel >= 30)
                write_reg(REG_DECAY, pick_gain());
            if (sel < 70)
                n = 2 * eff_delay() + $urandom_range(8, 60);
            else
                n = $urandom_range(16, 120);
            case ($urandom_range(0, 2))
                0: amp = 0;
                1: amp = 4096;
                default: amp = 256;
            endcase
            // sometimes drain mid-phase, with no register write in between
            if ($urandom_range(0, 7) == 0) begin
                push_random(n / 2, amp);
                wait_idle();
                push_random(n - n / 2, amp);
            end else begin
                push_random(n, amp);
            end
            rand_cnt += n;
            wait_idle();
        end

        repeat (20) @(posedge i_clk);
        if (fail_cnt == 0 && echo_exp_q.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // watchdog
    initial begin
        #2000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/fec_pkg.sv
hw/rtl/fec_ram.sv
hw/rtl/fec_mac.sv
hw/rtl/fec_oq.sv
hw/rtl/feedback_echo_comb.sv
verif/tb_feedback_echo_comb.sv
